FILE: sv/waveform_peak_finder_core_assert.svh
// Assertion macros shared by the waveform peak finder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef WAVEFORM_PEAK_FINDER_CORE_ASSERT_SVH
`define WAVEFORM_PEAK_FINDER_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define WPF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define WPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WPF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define WPF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/wpf_pkg.sv
// Types, constants and helpers for the waveform peak finder.
// No dependencies; imported by wpf_step and waveform_peak_finder_core.
`default_nettype none

package wpf_pkg;

    localparam int WAVEFORM_LENGTH = 512;
    localparam int POS_W           = $clog2(WAVEFORM_LENGTH);
    localparam int IDX_W           = 9;
    localparam int SAMPLE_W        = 12;
    localparam int RUN_W           = 5;
    localparam int COUNT_W         = 9;

    localparam logic [RUN_W-1:0]   RUN_RESET = RUN_W'(5);
    localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [POS_W-1:0]   LAST_POS  = POS_W'(WAVEFORM_LENGTH - 1);

    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [SAMPLE_W-1:0] smp_t;
    typedef logic [RUN_W-1:0]    run_t;
    typedef logic [COUNT_W-1:0]  cnt_t;

    // per-waveform tracking state
    typedef struct packed {
        smp_t prev_sample;
        pos_t position;
        run_t fall_count;
        pos_t cand_index;
        pos_t best_index;
        smp_t best_value;
        cnt_t peaks_seen;
        pos_t last_peak;
        logic last_peak_valid;
    } wpf_state_t;

    // one result beat, indices at full position width
    typedef struct packed {
        pos_t sample_index;
        logic peak_found;
        pos_t peak_index;
        pos_t max_index;
        smp_t max_value;
        cnt_t peak_count;
        logic waveform_done;
    } wpf_result_t;

    localparam wpf_state_t STATE_CLEAR = '0;

    // low IDX_W bits of a position, zero extended if positions are narrower
    function automatic logic [IDX_W-1:0] to_idx(input pos_t v);
        logic [POS_W+IDX_W-1:0] w;
        w = {{IDX_W{1'b0}}, v};
        return w[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/wpf_step.sv
// Single-sample update of the peak finder state, purely combinational.
// Depends on wpf_pkg.
`default_nettype none

module wpf_step
    import wpf_pkg::*;
(
    input  wire wpf_state_t  state,
    input  wire smp_t        sample,
    input  wire run_t        fall_run,
    output wpf_state_t       state_next,
    output wpf_result_t      result
);

    always_comb
    begin
        wpf_state_t s;
        logic       found;
        pos_t       pidx;

        s     = state;
        found = 1'b0;
        pidx  = '0;

        if (state.position == '0)
        begin
            s.best_value = sample;
            s.best_index = '0;
        end
        else
        begin
            if (state.best_value < sample)
            begin
                s.best_value = sample;
                s.best_index = state.position;
            end
            if (sample >= state.prev_sample)
            begin
                s.cand_index = state.position;
                s.fall_count = '0;
            end
            else if (state.fall_count < RUN_MAX)
            begin
                s.fall_count = state.fall_count + RUN_W'(1);
            end
            if (fall_run != '0 && s.fall_count == fall_run)
            begin
                found = 1'b1;
                pidx  = s.cand_index;
                // a re-confirmed index is counted once
                if (!state.last_peak_valid || state.last_peak != pidx)
                begin
                    if (state.peaks_seen < COUNT_MAX)
                        s.peaks_seen = state.peaks_seen + COUNT_W'(1);
                    s.last_peak       = pidx;
                    s.last_peak_valid = 1'b1;
                end
                s.fall_count = '0;
                s.cand_index = state.position - POS_W'(1);
            end
        end
        s.prev_sample = sample;

        result.sample_index  = state.position;
        result.peak_found    = found;
        result.peak_index    = pidx;
        result.max_index     = s.best_index;
        result.max_value     = s.best_value;
        result.peak_count    = s.peaks_seen;
        result.waveform_done = (state.position >= LAST_POS);

        if (result.waveform_done)
            state_next = STATE_CLEAR;
        else
        begin
            state_next          = s;
            state_next.position = state.position + POS_W'(1);
        end
    end

endmodule

`default_nettype wire

FILE: sv/waveform_peak_finder_core.sv
// Top level of the streaming waveform peak finder.
// Depends on wpf_pkg, wpf_step and waveform_peak_finder_core_assert.svh.
`default_nettype none

// Streaming peak finder for fixed-length detector waveforms. Feed one ADC
// sample per beat on the sample channel; every sample yields exactly one
// result beat carrying its position in the waveform, a peak flag with the
// peak's index, the first index and value of the largest sample so far,
// the number of distinct peaks so far and a last-sample flag. A peak is
// confirmed once fall_run consecutive samples have fallen below their
// predecessor (fall_run 0 disables detection). Waveform length is
// WAVEFORM_LENGTH samples (package constant); all tracking clears after
// the last one. Throughput is one sample per clock while result_stall is
// low. An accepted sample passes an input register, then the state update
// in wpf_step, which closes its loop through the state register, then the
// result register. fall_run resets to 5 and is written through the cfg
// channel, which is always ready; write it only while no samples are in
// flight.
module waveform_peak_finder_core
    import wpf_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,

    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire [RUN_W-1:0]        cfg_data,

    input  wire                    sample_valid,
    output logic                   sample_stall,
    input  wire [SAMPLE_W-1:0]     sample,

    output logic                   result_valid,
    input  wire                    result_stall,
    output logic [IDX_W-1:0]       sample_index,
    output logic                   peak_found,
    output logic [IDX_W-1:0]       peak_index,
    output logic [IDX_W-1:0]       max_index,
    output logic [SAMPLE_W-1:0]    max_value,
    output logic [COUNT_W-1:0]     peak_count,
    output logic                   waveform_done
);

    run_t        fall_run_reg;
    smp_t        sample_reg;
    logic        sample_valid_reg;
    wpf_state_t  state_reg;
    wpf_state_t  state_next;
    wpf_result_t result_reg;
    wpf_result_t result_next;
    logic        result_valid_reg;
    logic        advance;

    // config: single register, no backpressure
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fall_run_reg <= RUN_RESET;
        else if (cfg_valid && cfg_ready)
            fall_run_reg <= cfg_data;
    end

    // stage 1 moves on whenever the result register is free or draining
    assign advance      = sample_valid_reg && (!result_valid_reg || !result_stall);
    assign sample_stall = sample_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_valid_reg <= 1'b0;
        else if (!sample_stall)
            sample_valid_reg <= sample_valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && !sample_stall)
            sample_reg <= sample;
    end

    wpf_step u_step (
        .state      (state_reg),
        .sample     (sample_reg),
        .fall_run   (fall_run_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // tracking state updates only when a beat moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_CLEAR;
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid  = result_valid_reg;
    assign sample_index  = to_idx(result_reg.sample_index);
    assign peak_found    = result_reg.peak_found;
    assign peak_index    = to_idx(result_reg.peak_index);
    assign max_index     = to_idx(result_reg.max_index);
    assign max_value     = result_reg.max_value;
    assign peak_count    = result_reg.peak_count;
    assign waveform_done = result_reg.waveform_done;

`include "waveform_peak_finder_core_assert.svh"

    // a confirmed peak always lies before the sample that confirms it
    `WPF_ASSERT_SAME(a_peak_before_sample, clk, rst_n, result_valid_reg && result_reg.peak_found, result_reg.peak_index < result_reg.sample_index)
    // the last sample of a waveform rewinds the position
    `WPF_ASSERT_NEXT(a_wrap_clears, clk, rst_n, advance && result_next.waveform_done, state_reg.position == '0)
    // otherwise the position steps by one per processed sample
    `WPF_ASSERT_NEXT(a_pos_step, clk, rst_n, advance && !result_next.waveform_done, state_reg.position == $past(state_reg.position) + POS_W'(1))

endmodule

`default_nettype wire
